// ===== src/isu_pkg.sv =====
package isu_pkg;

    // Lattice geometry
    localparam int SIDE   = 64;
    localparam int NSITES = SIDE * SIDE;
    localparam int ROW_W  = $clog2(SIDE);
    localparam int AW     = $clog2(NSITES);

    // Field widths
    localparam int ACT_W     = 2;
    localparam int SITE_W    = 12;
    localparam int RND_W     = 16;
    localparam int THR_W     = 17;
    localparam int MAG_W     = 14;
    localparam int BOND_W    = 15;
    localparam int CFG_IDX_W = 2;

    // Row extraction: row = (site * RECIP) >> RSH, exact for every site below 2**SITE_W
    localparam int RSH    = SITE_W + 8;
    localparam int RECIP  = (2 ** RSH + SIDE - 1) / SIDE;
    localparam int PROD_W = SITE_W + RSH;

    // Action codes
    localparam logic [ACT_W-1:0] ACT_WRITE = 2'd0;
    localparam logic [ACT_W-1:0] ACT_FLIP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_THR_M4 = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_M2 = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_P2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_THR_P4 = 2'd3;

    localparam logic [THR_W-1:0] THR_M4_RST = 17'd65536;
    localparam logic [THR_W-1:0] THR_M2_RST = 17'd65536;
    localparam logic [THR_W-1:0] THR_P2_RST = 17'd0;
    localparam logic [THR_W-1:0] THR_P4_RST = 17'd0;

    // Totals after reset: every spin +1, every bond +1
    localparam logic [MAG_W-1:0]  MAG_RST  = MAG_W'(NSITES);
    localparam logic [BOND_W-1:0] BOND_RST = BOND_W'(2 * NSITES);

    // Job kinds handed from the front end to the execution engine
    typedef logic [1:0] t_kind;
    localparam t_kind KIND_NULL  = 2'd0;
    localparam t_kind KIND_WRITE = 2'd1;
    localparam t_kind KIND_FLIP  = 2'd2;
    localparam t_kind KIND_READ  = 2'd3;

    typedef struct packed {
        t_kind             kind;
        logic [AW-1:0]     site;
        logic [AW-1:0]     nb_up;
        logic [AW-1:0]     nb_down;
        logic [AW-1:0]     nb_left;
        logic [AW-1:0]     nb_right;
        logic [RND_W-1:0]  rnd;
        logic              wval;
    } t_job;

    // Job queue
    localparam int FIFO_DEPTH = 2;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

endpackage

// ===== src/isu_in_if.sv =====
interface isu_in_if;
    import isu_pkg::*;

    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [SITE_W-1:0] site;
    logic [RND_W-1:0]  random_fraction;
    logic              spin_value;

    modport source (output valid, action, site, random_fraction, spin_value, input ready);
    modport sink   (input valid, action, site, random_fraction, spin_value, output ready);
endinterface

// ===== src/isu_out_if.sv =====
interface isu_out_if;
    import isu_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     accepted;
    logic                     spin_now;
    logic signed [MAG_W-1:0]  magnetization;
    logic signed [BOND_W-1:0] bond_sum;

    modport source (output valid, accepted, spin_now, magnetization, bond_sum, input ready);
    modport sink   (input valid, accepted, spin_now, magnetization, bond_sum, output ready);
endinterface

// ===== src/isu_cfg_if.sv =====
interface isu_cfg_if;
    import isu_pkg::*;

    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [THR_W-1:0]     data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/ising_metropolis_spin_update_unit.sv =====
// The front end can take a new item while the execution engine works on the last one, but the engine
// takes no new item from the queue until it has finished the last. It reads the site and its four
// neighbours in turn through the two read ports of the spin memory.
// Reset (synchronous, active low) restores the thresholds and totals, then a clearing pass
// sets every spin to +1; no item is accepted during that pass.
module ising_metropolis_spin_update_unit (
    input  logic      i_clk,
    input  logic      i_rst_n,
    isu_in_if.sink    i_in,
    isu_out_if.source o_out,
    isu_cfg_if.sink   i_cfg
);
    import isu_pkg::*;

    // The front end registers each item, works out its row and column and the four
    // wrap-around neighbour addresses, and classifies it. A site past the lattice turns
    // into a null job that changes nothing.
    t_job front_job;
    logic front_push;

    // Queue between the two halves, so the front can take a new item while the engine works.
    t_job head_job;
    logic q_empty;
    logic q_full;

    // Engine handshake back to the queue, and its clearing status that holds off intake.
    logic pop;
    logic clearing;

    isu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_hold  (clearing),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (front_push),
        .o_job   (front_job)
    );

    isu_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_job   (front_job),
        .i_pop   (pop),
        .o_head  (head_job),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    // The engine holds the spin memory, the threshold registers and the running totals.
    // It applies the item and places the result in an output register, which decouples
    // it from a stalled consumer.
    isu_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_head     (head_job),
        .i_empty    (q_empty),
        .o_pop      (pop),
        .o_clearing (clearing),
        .i_cfg      (i_cfg),
        .o_out      (o_out)
    );

endmodule

// ===== src/isu_front.sv =====
module isu_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_hold,
    isu_in_if.sink        i_in,
    input  logic          i_full,
    output logic          o_push,
    output isu_pkg::t_job o_job
);
    import isu_pkg::*;

    logic              r_v;
    logic [ACT_W-1:0]  r_action;
    logic [SITE_W-1:0] r_site;
    logic [RND_W-1:0]  r_rnd;
    logic              r_wval;
    logic [ROW_W-1:0]  r_row;

    logic              accept;
    logic [PROD_W-1:0] row_prod;
    logic [AW-1:0]     site_a;
    logic [AW-1:0]     row_base;
    logic [AW-1:0]     col_full;
    logic [ROW_W-1:0]  col;
    logic              site_ok;

    assign i_in.ready = !i_hold && (!r_v || !i_full);
    assign accept     = i_in.valid && i_in.ready;
    assign o_push     = r_v && !i_full;

    // Row number taken by a reciprocal multiply on the way in.
    assign row_prod = PROD_W'(i_in.site) * PROD_W'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (accept) begin
            r_v <= 1'b1;
        end else if (o_push) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_action <= i_in.action;
            r_site   <= i_in.site;
            r_rnd    <= i_in.random_fraction;
            r_wval   <= i_in.spin_value;
            r_row    <= row_prod[RSH +: ROW_W];
        end
    end

    assign site_a   = AW'(r_site);
    assign row_base = AW'(32'(r_row) * SIDE);
    assign col_full = site_a - row_base;
    assign col      = col_full[ROW_W-1:0];
    assign site_ok  = 32'(r_site) < NSITES;

    always_comb begin
        o_job      = '0;
        o_job.site = site_a;
        o_job.rnd  = r_rnd;
        o_job.wval = r_wval;

        o_job.nb_right = (col == ROW_W'(SIDE - 1)) ? site_a - AW'(SIDE - 1) : site_a + AW'(1);
        o_job.nb_left  = (col == '0) ? site_a + AW'(SIDE - 1) : site_a - AW'(1);
        o_job.nb_down  = (r_row == ROW_W'(SIDE - 1)) ? site_a - AW'(NSITES - SIDE)
                                                      : site_a + AW'(SIDE);
        o_job.nb_up    = (r_row == '0) ? site_a + AW'(NSITES - SIDE) : site_a - AW'(SIDE);

        if (!site_ok) begin
            o_job.kind = KIND_NULL;
        end else begin
            unique case (r_action)
                ACT_WRITE: o_job.kind = KIND_WRITE;
                ACT_FLIP:  o_job.kind = KIND_FLIP;
                default:   o_job.kind = KIND_READ;
            endcase
        end
    end

endmodule

// ===== src/isu_fifo.sv =====
module isu_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  isu_pkg::t_job i_job,
    input  logic          i_pop,
    output isu_pkg::t_job o_head,
    output logic          o_empty,
    output logic          o_full
);
    import isu_pkg::*;

    t_job              r_slot [FIFO_DEPTH];
    logic [FPTR_W-1:0] r_wr_ptr;
    logic [FPTR_W-1:0] r_rd_ptr;
    logic [FCNT_W-1:0] r_cnt;

    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == FCNT_W'(FIFO_DEPTH));
    assign o_head  = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (i_pop && !i_push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_full |-> !i_push)
        else $error("job pushed into a full queue");
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_empty |-> !i_pop)
        else $error("job popped from an empty queue");

endmodule

// ===== src/isu_back.sv =====
module isu_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  isu_pkg::t_job i_head,
    input  logic          i_empty,
    output logic          o_pop,
    output logic          o_clearing,
    isu_cfg_if.sink       i_cfg,
    isu_out_if.source     o_out
);
    import isu_pkg::*;

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_RD1   = 3'd2;
    localparam logic [2:0] ST_RD2   = 3'd3;
    localparam logic [2:0] ST_EXEC  = 3'd4;

    logic [2:0]        r_state;
    logic [2:0]        n_state;
    logic [AW-1:0]     r_clr;
    t_job              r_job;
    logic              r_s;
    logic              r_nu;
    logic              r_nl;
    logic              r_nr;

    logic [THR_W-1:0]  r_th_m4;
    logic [THR_W-1:0]  r_th_m2;
    logic [THR_W-1:0]  r_th_p2;
    logic [THR_W-1:0]  r_th_p4;

    logic [MAG_W-1:0]  r_mag;
    logic [BOND_W-1:0] r_bond;

    logic              r_out_v;
    logic              r_out_acc;
    logic              r_out_now;

    // Spin memory: one write port, two registered read ports
    logic              mem [NSITES];
    logic [AW-1:0]     addr_a;
    logic [AW-1:0]     addr_b;
    logic              q_a;
    logic              q_b;
    logic              we;
    logic [AW-1:0]     wa;
    logic              wd;

    logic [2:0]        ones;
    logic [2:0]        agree;
    logic [THR_W-1:0]  rnd_x;
    logic              take;
    logic              change;
    logic              load;
    logic [BOND_W-1:0] bond_d;

    assign i_cfg.ready   = 1'b1;
    assign o_clearing    = (r_state == ST_CLEAR);
    assign o_pop         = (r_state == ST_IDLE) && !i_empty;
    assign load          = (r_state == ST_EXEC) && (!r_out_v || o_out.ready);

    assign o_out.valid         = r_out_v;
    assign o_out.accepted      = r_out_acc;
    assign o_out.spin_now      = r_out_now;
    assign o_out.magnetization = r_mag;
    assign o_out.bond_sum      = r_bond;

    // Read address sequencing: site and up, then left and right, then down
    always_comb begin
        addr_a = r_job.nb_down;
        addr_b = r_job.nb_down;
        case (r_state)
            ST_IDLE: begin
                addr_a = i_head.site;
                addr_b = i_head.nb_up;
            end
            ST_RD1: begin
                addr_a = r_job.nb_left;
                addr_b = r_job.nb_right;
            end
            default: begin
                addr_a = r_job.nb_down;
                addr_b = r_job.nb_down;
            end
        endcase
    end

    // Decision: count neighbours that agree with the spin, 2*agree-4 is s*sum
    assign ones  = {2'b00, r_nu} + {2'b00, r_nl} + {2'b00, r_nr} + {2'b00, q_a};
    assign agree = r_s ? ones : 3'd4 - ones;
    assign rnd_x = {1'b0, r_job.rnd};

    always_comb begin
        case (agree)
            3'd0:    take = rnd_x < r_th_m4;
            3'd1:    take = rnd_x < r_th_m2;
            3'd3:    take = rnd_x < r_th_p2;
            3'd4:    take = rnd_x < r_th_p4;
            default: take = 1'b1;
        endcase
    end

    assign change = ((r_job.kind == KIND_WRITE) && (r_job.wval != r_s))
                 || ((r_job.kind == KIND_FLIP) && take);
    assign bond_d = BOND_W'(8) - BOND_W'({agree, 2'b00});

    always_comb begin
        we = 1'b0;
        wa = r_job.site;
        wd = !r_s;
        if (r_state == ST_CLEAR) begin
            we = 1'b1;
            wa = r_clr;
            wd = 1'b1;
        end else if (load && change) begin
            we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wa] <= wd;
        end
        q_a <= mem[addr_a];
        q_b <= mem[addr_b];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr == AW'(NSITES - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (!i_empty) n_state = ST_RD1;
            ST_RD1:   n_state = ST_RD2;
            ST_RD2:   n_state = ST_EXEC;
            ST_EXEC:  if (load) n_state = ST_IDLE;
            default:  n_state = ST_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_out_v <= 1'b0;
            r_mag   <= MAG_RST;
            r_bond  <= BOND_RST;
            r_th_m4 <= THR_M4_RST;
            r_th_m2 <= THR_M2_RST;
            r_th_p2 <= THR_P2_RST;
            r_th_p4 <= THR_P4_RST;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg.valid) begin
                unique case (i_cfg.index)
                    CFG_THR_M4: r_th_m4 <= i_cfg.data;
                    CFG_THR_M2: r_th_m2 <= i_cfg.data;
                    CFG_THR_P2: r_th_p2 <= i_cfg.data;
                    CFG_THR_P4: r_th_p4 <= i_cfg.data;
                    default:    r_th_m4 <= r_th_m4;
                endcase
            end
            if (load) begin
                r_out_v <= 1'b1;
            end else if (o_out.ready) begin
                r_out_v <= 1'b0;
            end
            if (load && change) begin
                r_mag  <= r_s ? r_mag - MAG_W'(2) : r_mag + MAG_W'(2);
                r_bond <= r_bond + bond_d;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_job <= i_head;
        end
        if (r_state == ST_RD1) begin
            r_s  <= q_a;
            r_nu <= q_b;
        end
        if (r_state == ST_RD2) begin
            r_nl <= q_a;
            r_nr <= q_b;
        end
        if (load) begin
            r_out_acc <= (r_job.kind == KIND_FLIP) && take;
            r_out_now <= (r_job.kind == KIND_NULL) ? 1'b0 : (r_s ^ change);
        end
    end

    a_mag_parity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mag[0] == MAG_RST[0])
        else $error("magnetization left its parity class");
    a_bond_mod4: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bond[1:0] == BOND_RST[1:0])
        else $error("bond sum changed by a step that is not a multiple of four");
    a_no_pop_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR) |-> !o_pop)
        else $error("job taken during the clearing pass");

endmodule
